// ===== sv/bpa_pkg.sv =====
// Shared types, constants and codes of the bitmap page allocator.
package bpa_pkg;

   localparam int PAGE_BYTES = 4096;
   localparam int PAGE_LIMIT = 32768;
   localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);

   localparam int ADDR_W  = 27;
   localparam int LEN_W   = 28;
   localparam int COUNT_W = 16;
   localparam int STAT_W  = 2;
   localparam int KIND_W  = 2;

   // bitmap words
   localparam int WORD_W     = 32;
   localparam int BIT_W      = $clog2(WORD_W);
   localparam int MAP_WORDS  = (PAGE_LIMIT + WORD_W - 1) / WORD_W;
   localparam int WIDX_W     = $clog2(MAP_WORDS);
   localparam int POP_W      = BIT_W + 1;

   // page arithmetic: end of region sum and a page number wide enough for both
   localparam int SUM_W   = LEN_W + 1;
   localparam int END_W   = SUM_W - PAGE_SHIFT;
   localparam int LIMIT_W = $clog2(PAGE_LIMIT + 1);
   localparam int PN_W    = (END_W > LIMIT_W) ? END_W : LIMIT_W;
   localparam int PAGE_W  = WIDX_W + BIT_W;

   localparam int REQ_DATA_W = ((ADDR_W + LEN_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((ADDR_W + COUNT_W + 7) / 8) * 8;

   localparam logic [WORD_W-1:0] ALL_USED = '1;

   typedef enum logic [KIND_W-1:0] {
      REQ_ALLOC     = 2'd0,
      REQ_FREE      = 2'd1,
      REQ_MARK_USED = 2'd2,
      REQ_MARK_FREE = 2'd3
   } req_kind_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_DONE    = 2'd0,
      STAT_OOM     = 2'd1,
      STAT_IGNORED = 2'd2
   } rsp_status_type;

   typedef enum logic [2:0] {
      ST_FILL,
      ST_IDLE,
      ST_DECODE,
      ST_READ,
      ST_EVAL,
      ST_RESP
   } ctrl_state_type;

   typedef struct packed {
      logic fill_wr;
      logic load;
      logic decode;
      logic read;
      logic eval;
      logic out_load;
   } dp_cmd_type;

   typedef struct packed {
      logic fill_last;
      logic skip;
      logic eval_done;
      logic out_free;
   } dp_stat_type;

endpackage

// ===== sv/bitmap_page_allocator.sv =====
// Top level of the first-fit bitmap page allocator.
// Steps: decode, then a read and an evaluate state per bitmap word scanned for alloc (up to
// all 1024 words), for the one word of a free (none for address zero) and for each 32-page
// word a mark touches (none for an empty region); the single-port bitmap memory has a registered read.
// Throughput: one request at a time; the next is taken once the result is registered.
// Reset: synchronous; a fill pass over all 1024 bitmap words marks every page used, no request taken.
module bitmap_page_allocator (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // req_tdata: byte_address [26:0], region_length [54:27], zero pad
   input  logic [bpa_pkg::REQ_DATA_W-1:0]     req_tdata,
   // req_tuser: req_type [1:0]
   input  logic [bpa_pkg::KIND_W-1:0]         req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // rsp_tdata: page_address [26:0], free_count [42:27], zero pad
   output logic [bpa_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // rsp_tuser: status [1:0]
   output logic [bpa_pkg::STAT_W-1:0]         rsp_tuser
);

   bpa_pkg::dp_cmd_type  dp_cmd;
   bpa_pkg::dp_stat_type dp_stat;
   logic                 req_accept;

   // request handshake
   assign req_accept = req_tvalid && req_tready;

   bpa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_accept (req_accept),
      .dp_stat    (dp_stat),
      .dp_cmd     (dp_cmd),
      .req_tready (req_tready)
   );

   // bitmap, counter and result register
   bpa_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .dp_cmd     (dp_cmd),
      .dp_stat    (dp_stat),
      .req_kind   (req_tuser),
      .req_addr   (req_tdata[bpa_pkg::ADDR_W-1:0]),
      .req_len    (req_tdata[bpa_pkg::ADDR_W+bpa_pkg::LEN_W-1:bpa_pkg::ADDR_W]),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// ===== sv/bpa_ctrl.sv =====
// Sequencing state machine of the bitmap page allocator.
module bpa_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_accept,
   input  bpa_pkg::dp_stat_type dp_stat,
   output bpa_pkg::dp_cmd_type  dp_cmd,
   output logic                 req_tready
);

   bpa_pkg::ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bpa_pkg::ST_FILL;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bpa_pkg::ST_FILL: begin
            if (dp_stat.fill_last) state_in = bpa_pkg::ST_IDLE;
         end
         bpa_pkg::ST_IDLE: begin
            if (req_accept) state_in = bpa_pkg::ST_DECODE;
         end
         bpa_pkg::ST_DECODE: begin
            state_in = dp_stat.skip ? bpa_pkg::ST_RESP : bpa_pkg::ST_READ;
         end
         bpa_pkg::ST_READ: begin
            state_in = bpa_pkg::ST_EVAL;
         end
         bpa_pkg::ST_EVAL: begin
            state_in = dp_stat.eval_done ? bpa_pkg::ST_RESP : bpa_pkg::ST_READ;
         end
         bpa_pkg::ST_RESP: begin
            if (dp_stat.out_free) state_in = bpa_pkg::ST_IDLE;
         end
         default: begin
            state_in = bpa_pkg::ST_FILL;
         end
      endcase
   end

   always_comb begin
      dp_cmd     = '0;
      req_tready = 1'b0;
      case (state_ff)
         bpa_pkg::ST_FILL: begin
            dp_cmd.fill_wr = 1'b1;
         end
         bpa_pkg::ST_IDLE: begin
            req_tready  = 1'b1;
            dp_cmd.load = req_accept;
         end
         bpa_pkg::ST_DECODE: begin
            dp_cmd.decode = 1'b1;
         end
         bpa_pkg::ST_READ: begin
            dp_cmd.read = 1'b1;
         end
         bpa_pkg::ST_EVAL: begin
            dp_cmd.eval = 1'b1;
         end
         bpa_pkg::ST_RESP: begin
            dp_cmd.out_load = dp_stat.out_free;
         end
         default: begin
            dp_cmd = '0;
         end
      endcase
   end

endmodule

// ===== sv/bpa_dpath.sv =====
// Bitmap memory, request registers, free counter and result register.
module bpa_dpath (
   input  logic                               clock,
   input  logic                               reset,
   input  bpa_pkg::dp_cmd_type                dp_cmd,
   output bpa_pkg::dp_stat_type               dp_stat,
   input  logic [bpa_pkg::KIND_W-1:0]         req_kind,
   input  logic [bpa_pkg::ADDR_W-1:0]         req_addr,
   input  logic [bpa_pkg::LEN_W-1:0]          req_len,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [bpa_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic [bpa_pkg::STAT_W-1:0]         rsp_tuser
);

   localparam int WW = bpa_pkg::WORD_W;
   localparam int BW = bpa_pkg::BIT_W;
   localparam int XW = bpa_pkg::WIDX_W;
   localparam int PW = bpa_pkg::PN_W;

   logic [WW-1:0] map_ff [bpa_pkg::MAP_WORDS];
   logic [WW-1:0] rd_ff;

   logic [bpa_pkg::KIND_W-1:0] kind_ff;
   logic [bpa_pkg::ADDR_W-1:0] addr_ff;
   logic [bpa_pkg::LEN_W-1:0]  len_ff;

   logic [XW-1:0] widx_ff, widx_in;
   logic [XW-1:0] first_w_ff, first_w_in, last_w_ff, last_w_in;
   logic [BW-1:0] lo_b_ff, lo_b_in, hi_b_ff, hi_b_in;

   logic [bpa_pkg::COUNT_W-1:0] count_ff, count_in;
   logic [bpa_pkg::ADDR_W-1:0]  res_addr_ff, res_addr_in;
   logic [bpa_pkg::STAT_W-1:0]  res_stat_ff, res_stat_in;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic [bpa_pkg::RSP_DATA_W-1:0] rsp_data_ff;
   logic [bpa_pkg::STAT_W-1:0]     rsp_user_ff;

   // decode of the registered request
   logic [bpa_pkg::SUM_W-1:0] end_sum;
   logic [PW-1:0]             first_pg, end_pg, end_clip, last_pg, lim_pg;
   logic                      skip;
   logic [bpa_pkg::STAT_W-1:0] skip_stat;

   // evaluation of one bitmap word
   logic          mem_we;
   logic [WW-1:0] mem_wdata;
   logic          eval_done;
   logic          zero_found;
   logic [BW-1:0] zero_pos;
   logic [BW-1:0] lo_sel, hi_sel;
   logic [WW-1:0] mark_mask, changed;
   logic [bpa_pkg::POP_W-1:0] pop;
   logic [bpa_pkg::PAGE_W-1:0] alloc_pg;

   function automatic logic [WW-1:0] ALL_ONES_W();
      return bpa_pkg::ALL_USED;
   endfunction

   always_comb begin
      lim_pg    = PW'(bpa_pkg::PAGE_LIMIT);
      first_pg  = PW'(addr_ff >> bpa_pkg::PAGE_SHIFT);
      end_sum   = bpa_pkg::SUM_W'(addr_ff) + bpa_pkg::SUM_W'(len_ff)
                  + bpa_pkg::SUM_W'(bpa_pkg::PAGE_BYTES - 1);
      end_pg    = PW'(end_sum >> bpa_pkg::PAGE_SHIFT);
      end_clip  = (end_pg > lim_pg) ? lim_pg : end_pg;
      last_pg   = end_clip - PW'(1);
      skip      = 1'b0;
      skip_stat = bpa_pkg::STAT_DONE;
      first_w_in = first_w_ff;
      last_w_in  = last_w_ff;
      lo_b_in    = lo_b_ff;
      hi_b_in    = hi_b_ff;
      case (bpa_pkg::req_kind_type'(kind_ff))
         bpa_pkg::REQ_ALLOC: begin
            first_w_in = '0;
         end
         bpa_pkg::REQ_FREE: begin
            skip       = (addr_ff == '0) || (first_pg >= lim_pg);
            skip_stat  = bpa_pkg::STAT_IGNORED;
            first_w_in = XW'(first_pg >> BW);
            lo_b_in    = first_pg[BW-1:0];
         end
         default: begin
            skip       = first_pg >= end_clip;
            first_w_in = XW'(first_pg >> BW);
            last_w_in  = XW'(last_pg >> BW);
            lo_b_in    = first_pg[BW-1:0];
            hi_b_in    = last_pg[BW-1:0];
         end
      endcase
   end

   // lowest clear bit of the word just read
   always_comb begin
      zero_found = 1'b0;
      zero_pos   = '0;
      for (int i = WW - 1; i >= 0; i--) begin
         if (!rd_ff[i]) begin
            zero_found = 1'b1;
            zero_pos   = BW'(i);
         end
      end
   end

   always_comb begin
      lo_sel    = (widx_ff == first_w_ff) ? lo_b_ff : '0;
      hi_sel    = (widx_ff == last_w_ff) ? hi_b_ff : BW'(WW - 1);
      mark_mask = (ALL_ONES_W() << lo_sel) & (ALL_ONES_W() >> (BW'(WW - 1) - hi_sel));
      changed   = (bpa_pkg::req_kind_type'(kind_ff) == bpa_pkg::REQ_MARK_USED)
                  ? (mark_mask & ~rd_ff) : (mark_mask & rd_ff);
      pop       = bpa_pkg::POP_W'($countones(changed));
      alloc_pg  = {widx_ff, zero_pos};
   end

   always_comb begin
      mem_we      = 1'b0;
      mem_wdata   = rd_ff;
      eval_done   = 1'b1;
      count_in    = count_ff;
      res_addr_in = res_addr_ff;
      res_stat_in = res_stat_ff;
      if (dp_cmd.decode) begin
         res_addr_in = '0;
         res_stat_in = skip_stat;
      end
      if (dp_cmd.eval) begin
         case (bpa_pkg::req_kind_type'(kind_ff))
            bpa_pkg::REQ_ALLOC: begin
               eval_done = zero_found || (widx_ff == XW'(bpa_pkg::MAP_WORDS - 1));
               if (zero_found) begin
                  mem_we      = 1'b1;
                  mem_wdata   = rd_ff | (WW'(1) << zero_pos);
                  count_in    = count_ff - bpa_pkg::COUNT_W'(1);
                  res_addr_in = bpa_pkg::ADDR_W'(
                     {{bpa_pkg::PAGE_SHIFT{1'b0}}, alloc_pg} << bpa_pkg::PAGE_SHIFT);
                  res_stat_in = bpa_pkg::STAT_DONE;
               end else begin
                  res_stat_in = bpa_pkg::STAT_OOM;
               end
            end
            bpa_pkg::REQ_FREE: begin
               if (rd_ff[lo_b_ff]) begin
                  mem_we      = 1'b1;
                  mem_wdata   = rd_ff & ~(WW'(1) << lo_b_ff);
                  count_in    = count_ff + bpa_pkg::COUNT_W'(1);
                  res_stat_in = bpa_pkg::STAT_DONE;
               end else begin
                  res_stat_in = bpa_pkg::STAT_IGNORED;
               end
            end
            bpa_pkg::REQ_MARK_USED: begin
               eval_done = widx_ff == last_w_ff;
               mem_we    = 1'b1;
               mem_wdata = rd_ff | mark_mask;
               count_in  = count_ff - bpa_pkg::COUNT_W'(pop);
            end
            default: begin
               eval_done = widx_ff == last_w_ff;
               mem_we    = 1'b1;
               mem_wdata = rd_ff & ~mark_mask;
               count_in  = count_ff + bpa_pkg::COUNT_W'(pop);
            end
         endcase
      end
   end

   always_comb begin
      widx_in = widx_ff;
      if (dp_cmd.fill_wr) begin
         widx_in = widx_ff + XW'(1);
      end else if (dp_cmd.decode) begin
         widx_in = first_w_in;
      end else if (dp_cmd.eval && !eval_done) begin
         widx_in = widx_ff + XW'(1);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (dp_cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // bitmap memory: one write port, registered read
   always_ff @(posedge clock) begin
      if (dp_cmd.fill_wr) begin
         map_ff[widx_ff] <= bpa_pkg::ALL_USED;
      end else if (mem_we) begin
         map_ff[widx_ff] <= mem_wdata;
      end
      if (dp_cmd.read) begin
         rd_ff <= map_ff[widx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         widx_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         widx_ff      <= widx_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.load) begin
         kind_ff <= req_kind;
         addr_ff <= req_addr;
         len_ff  <= req_len;
      end
      if (dp_cmd.decode) begin
         first_w_ff <= first_w_in;
         last_w_ff  <= last_w_in;
         lo_b_ff    <= lo_b_in;
         hi_b_ff    <= hi_b_in;
      end
      res_addr_ff <= res_addr_in;
      res_stat_ff <= res_stat_in;
      if (dp_cmd.out_load) begin
         rsp_data_ff <= bpa_pkg::RSP_DATA_W'({count_ff, res_addr_ff});
         rsp_user_ff <= res_stat_ff;
      end
   end

   assign dp_stat.fill_last = widx_ff == XW'(bpa_pkg::MAP_WORDS - 1);
   assign dp_stat.skip      = skip;
   assign dp_stat.eval_done = eval_done;
   assign dp_stat.out_free  = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

// ===== tb/bitmap_page_allocator_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench of the bitmap page allocator: directed corners, then random requests.
module bitmap_page_allocator_tb;

   localparam int ADDR_W     = bpa_pkg::ADDR_W;
   localparam int LEN_W      = bpa_pkg::LEN_W;
   localparam int COUNT_W    = bpa_pkg::COUNT_W;
   localparam int STAT_W     = bpa_pkg::STAT_W;
   localparam int KIND_W     = bpa_pkg::KIND_W;
   localparam int REQ_DATA_W = bpa_pkg::REQ_DATA_W;
   localparam int RSP_DATA_W = bpa_pkg::RSP_DATA_W;
   localparam int PAGE_BYTES = bpa_pkg::PAGE_BYTES;
   localparam int PAGE_LIMIT = bpa_pkg::PAGE_LIMIT;

   localparam int WATCHDOG_LIMIT = 40000;
   localparam int MAX_SHOWN      = 10;
   localparam logic [LEN_W-1:0] FULL_SPAN = 28'd134217728;

   typedef struct packed {
      logic [ADDR_W-1:0]       page_address;
      bpa_pkg::rsp_status_type status;
      logic [COUNT_W-1:0]      free_count;
   } alloc_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [KIND_W-1:0] req_tuser = bpa_pkg::REQ_ALLOC;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [STAT_W-1:0] rsp_tuser;

   // predictor state: one used bit per page, plus the free counter
   bit              page_busy [PAGE_LIMIT];
   int unsigned     free_total;
   alloc_rsp_type   pending_rsp [$];
   int unsigned     held_pages [$];
   int unsigned     mismatches = 0;
   int unsigned     quiet_cycles = 0;
   int unsigned     rsp_stall = 0;
   bit              no_idle = 1'b0;

   always #4 clock = ~clock;

   bitmap_page_allocator i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // Works out the response to one request and updates the page map.
   function automatic alloc_rsp_type serve_request(bpa_pkg::req_kind_type kind,
                                                   logic [ADDR_W-1:0] addr,
                                                   logic [LEN_W-1:0] len);
      alloc_rsp_type rsp;
      longint unsigned first_pg, end_pg, pg;
      bit found;
      rsp = '{page_address: '0, status: bpa_pkg::STAT_DONE, free_count: '0};
      found = 1'b0;
      case (kind)
         bpa_pkg::REQ_ALLOC: begin
            for (int p = 0; p < PAGE_LIMIT && !found; p++) begin
               if (!page_busy[p]) begin
                  found = 1'b1;
                  page_busy[p] = 1'b1;
                  free_total--;
                  rsp.page_address = ADDR_W'(longint'(p) * PAGE_BYTES);
                  held_pages.push_back(p);
               end
            end
            if (!found) rsp.status = bpa_pkg::STAT_OOM;
         end
         bpa_pkg::REQ_FREE: begin
            pg = addr / PAGE_BYTES;
            if (addr == 0 || pg >= PAGE_LIMIT || !page_busy[pg]) begin
               rsp.status = bpa_pkg::STAT_IGNORED;
            end else begin
               page_busy[pg] = 1'b0;
               free_total++;
            end
         end
         default: begin
            // region rounded out to whole pages, clipped at the page limit
            first_pg = longint'(addr) / PAGE_BYTES;
            end_pg = (longint'(addr) + longint'(len) + PAGE_BYTES - 1) / PAGE_BYTES;
            if (end_pg > PAGE_LIMIT) end_pg = PAGE_LIMIT;
            for (pg = first_pg; pg < end_pg; pg++) begin
               if (kind == bpa_pkg::REQ_MARK_USED && !page_busy[pg]) begin
                  page_busy[pg] = 1'b1;
                  free_total--;
               end else if (kind == bpa_pkg::REQ_MARK_FREE && page_busy[pg]) begin
                  page_busy[pg] = 1'b0;
                  free_total++;
               end
            end
         end
      endcase
      rsp.free_count = COUNT_W'(free_total);
      return rsp;
   endfunction

   // Sends one request; valid stays high across back-to-back requests.
   task automatic send_request(bpa_pkg::req_kind_type kind, logic [ADDR_W-1:0] addr,
                               logic [LEN_W-1:0] len);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_DATA_W'({len, addr});
      req_tuser  <= kind;
      do @(posedge clock); while (!req_tready);
      pending_rsp.push_back(serve_request(kind, addr, len));
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
   endtask

   task automatic test_directed();
      send_request(bpa_pkg::REQ_ALLOC, '0, '0);              // nothing free yet: out of memory
      send_request(bpa_pkg::REQ_FREE, '0, '0);               // address zero ignored
      send_request(bpa_pkg::REQ_FREE, 27'h0005123, '0);      // frees page 5
      send_request(bpa_pkg::REQ_FREE, 27'h0005000, '0);      // already free
      send_request(bpa_pkg::REQ_MARK_FREE, 27'h0010000, '0); // aligned, zero length: no pages
      send_request(bpa_pkg::REQ_MARK_FREE, 27'h0000064, '0); // unaligned, zero length: page 0
      send_request(bpa_pkg::REQ_ALLOC, '0, '0);              // page 0, address zero, done
      send_request(bpa_pkg::REQ_ALLOC, '0, '0);              // page 5
      send_request(bpa_pkg::REQ_ALLOC, '0, '0);              // out of memory
      send_request(bpa_pkg::REQ_MARK_FREE, 27'h7FFF000, FULL_SPAN);  // tail clipped at the limit
      send_request(bpa_pkg::REQ_ALLOC, '0, '0);              // top page
      send_request(bpa_pkg::REQ_FREE, 27'h7FFFFFF, '0);      // top page back
      send_request(bpa_pkg::REQ_MARK_FREE, '0, FULL_SPAN);   // whole memory free
      send_request(bpa_pkg::REQ_ALLOC, '0, '0);
      send_request(bpa_pkg::REQ_MARK_USED, 27'h0003FFF, 28'h0000002);  // straddles two pages
      send_request(bpa_pkg::REQ_ALLOC, '0, '0);
      send_request(bpa_pkg::REQ_MARK_USED, '0, FULL_SPAN);   // whole memory used
      send_request(bpa_pkg::REQ_ALLOC, '0, '0);
      send_request(bpa_pkg::REQ_MARK_FREE, 27'h0001000, 28'h0008000);
      send_request(bpa_pkg::REQ_MARK_USED, 27'h7FFFFFF, 28'hFFFFFFF);  // widest fields
      send_request(bpa_pkg::REQ_FREE, 27'h0001000, '0);
   endtask

   task automatic test_random(int count);
      int unsigned pick, idx;
      logic [ADDR_W-1:0] addr;
      logic [LEN_W-1:0] len;
      for (int n = 0; n < count; n++) begin
         if (n % 200 == 0) no_idle = ($urandom_range(0, 2) == 0);
         if (n == count / 2) wait_drained();      // sender holds off until all answered
         pick = $urandom_range(0, 99);
         addr = ADDR_W'($urandom_range(0, 255 * PAGE_BYTES));
         len  = LEN_W'($urandom_range(0, 6 * PAGE_BYTES));
         if (pick < 35) begin
            send_request(bpa_pkg::REQ_ALLOC, ADDR_W'($urandom), LEN_W'($urandom));
         end else if (pick < 60) begin
            if (held_pages.size() != 0 && $urandom_range(0, 3) != 0) begin
               idx = $urandom_range(0, held_pages.size() - 1);
               addr = ADDR_W'(held_pages[idx] * PAGE_BYTES
                              + $urandom_range(0, PAGE_BYTES - 1));
               held_pages.delete(idx);
            end else begin
               addr = ADDR_W'($urandom);
            end
            send_request(bpa_pkg::REQ_FREE, addr, LEN_W'($urandom));
         end else if (pick < 98) begin
            send_request(pick < 75 ? bpa_pkg::REQ_MARK_USED : bpa_pkg::REQ_MARK_FREE,
                         addr, len);
         end else begin
            // rare wide region anywhere in memory
            send_request(pick[0] ? bpa_pkg::REQ_MARK_USED : bpa_pkg::REQ_MARK_FREE,
                         ADDR_W'($urandom), LEN_W'($urandom_range(0, FULL_SPAN)));
         end
      end
   endtask

   // Response side: random stall per response, field-by-field compare.
   always @(posedge clock) begin
      alloc_rsp_type want;
      int unsigned   next_stall;
      logic          ready_next;
      next_stall = rsp_stall;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_SHOWN)
               $display("unexpected response: addr %h count %0d status %0d",
                        rsp_tdata[ADDR_W-1:0], rsp_tdata[ADDR_W+COUNT_W-1:ADDR_W], rsp_tuser);
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_tdata[ADDR_W-1:0] !== want.page_address ||
                rsp_tdata[ADDR_W+COUNT_W-1:ADDR_W] !== want.free_count ||
                rsp_tuser !== want.status) begin
               mismatches++;
               if (mismatches <= MAX_SHOWN)
                  $display({"mismatch: addr exp %h got %h, count exp %0d got %0d, ",
                            "status exp %0d got %0d"},
                           want.page_address, rsp_tdata[ADDR_W-1:0], want.free_count,
                           rsp_tdata[ADDR_W+COUNT_W-1:ADDR_W], want.status, rsp_tuser);
            end
         end
         next_stall = no_idle ? 0 : $urandom_range(0, 4);
      end else if (next_stall > 0) begin
         next_stall--;
      end
      rsp_stall = next_stall;
      ready_next = !reset && next_stall == 0;
      rsp_tready <= ready_next;
   end

   // Watchdog on cycles with no handshake on either side.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("bitmap_page_allocator_tb failed");
         $finish;
      end
   end

   initial begin
      for (int p = 0; p < PAGE_LIMIT; p++) page_busy[p] = 1'b1;
      free_total = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random(1330);
      wait_drained();
      repeat (2200) @(posedge clock);
      if (mismatches == 0 && pending_rsp.size() == 0) begin
         $display("bitmap_page_allocator_tb passed");
      end else begin
         $display("bitmap_page_allocator_tb failed");
      end
      $finish;
   end

endmodule
